// ===== rtl/core/fas_pkg.sv =====
// ----------------------------------------------------------------------------
// fas_pkg
// shared constants and types for the single-precision add/subtract pipeline
// ----------------------------------------------------------------------------
package fas_pkg;

   localparam int unsigned WORD_W = 32;
   localparam int unsigned EXP_W  = 8;
   localparam int unsigned FRAC_W = 23;
   localparam int unsigned SIG_W  = 24;
   localparam int unsigned SUM_W  = 25;
   localparam logic [4:0]  MAX_SHIFT = 5'd23;
   localparam logic        OP_ADD = 1'b0;
   localparam logic        OP_SUB = 1'b1;

   // stage 1 to stage 2: aligned operands
   typedef struct packed {
      logic              bypass;
      logic [WORD_W-1:0] bypass_word;
      logic              sign;
      logic [EXP_W-1:0]  exp;
      logic [SIG_W-1:0]  big;
      logic [SIG_W-1:0]  minor;
      logic              subtract;
   } align_type;

   // stage 2 to stage 3: raw sum
   typedef struct packed {
      logic              bypass;
      logic [WORD_W-1:0] bypass_word;
      logic              sign;
      logic [EXP_W-1:0]  exp;
      logic [SUM_W-1:0]  sum;
   } sum_type;

endpackage

// ===== rtl/core/fas_align.sv =====
// ----------------------------------------------------------------------------
// fas_align
// unpacks operands, orders by magnitude and right-shifts the smaller one
// ----------------------------------------------------------------------------
module fas_align
   import fas_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [WORD_W-1:0] operand_a,
   input  logic [WORD_W-1:0] operand_b,
   input  logic              opcode,
   output logic              out_valid,
   output align_type         out_data
);

   logic              valid_ff;
   align_type         data_ff, data_in;
   logic              sa, sb, a_big;
   logic [EXP_W-1:0]  ea, eb;
   logic [FRAC_W-1:0] ma, mb;
   logic [EXP_W-1:0]  diff;
   logic [SIG_W-1:0]  minor_raw;

   // unpack and order
   always_comb begin
      sa = operand_a[31];
      sb = operand_b[31] ^ (opcode == OP_SUB);
      ea = operand_a[30:23];
      eb = operand_b[30:23];
      ma = operand_a[22:0];
      mb = operand_b[22:0];
      a_big = (ea > eb) || ((ea == eb) && (ma > mb));
      data_in.bypass = (ea == '0) || (eb == '0);
      data_in.bypass_word = (ea == '0) ? {sb, operand_b[30:0]} : operand_a;
      data_in.subtract = sa != sb;
      if (a_big) begin
         data_in.sign = sa;
         data_in.exp = ea;
         data_in.big = {1'b1, ma};
         minor_raw = {1'b1, mb};
         diff = ea - eb;
      end else begin
         data_in.sign = sb;
         data_in.exp = eb;
         data_in.big = {1'b1, mb};
         minor_raw = {1'b1, ma};
         diff = eb - ea;
      end
      data_in.minor = (diff > {3'b000, MAX_SHIFT}) ? '0 : (minor_raw >> diff[4:0]);
   end

   // stage register
   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= in_valid;
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== rtl/core/fas_addsub.sv =====
// ----------------------------------------------------------------------------
// fas_addsub
// adds or subtracts the aligned significands
// ----------------------------------------------------------------------------
module fas_addsub
   import fas_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   input  align_type in_data,
   output logic      out_valid,
   output sum_type   out_data
);

   logic    valid_ff;
   sum_type data_ff, data_in;

   // significand add
   always_comb begin
      data_in.bypass = in_data.bypass;
      data_in.bypass_word = in_data.bypass_word;
      data_in.sign = in_data.sign;
      data_in.exp = in_data.exp;
      if (in_data.subtract)
         data_in.sum = {1'b0, in_data.big} - {1'b0, in_data.minor};
      else
         data_in.sum = {1'b0, in_data.big} + {1'b0, in_data.minor};
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= in_valid;
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== rtl/core/fas_norm.sv =====
// ----------------------------------------------------------------------------
// fas_norm
// leading-one search, normalize shift and result packing
// ----------------------------------------------------------------------------
module fas_norm
   import fas_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  sum_type           in_data,
   output logic              out_valid,
   output logic [WORD_W-1:0] out_word
);

   logic              valid_ff;
   logic [WORD_W-1:0] word_ff, word_in;
   logic [4:0]        lz;
   logic              found;
   logic [SUM_W-1:0]  shifted;
   logic [EXP_W-1:0]  exp_new;

   // leading-one search below the carry bit
   always_comb begin
      lz = '0;
      found = 1'b0;
      for (int i = SIG_W - 1; i >= 0; i--) begin
         if (!found && in_data.sum[i]) begin
            found = 1'b1;
            lz = 5'(SIG_W - 1 - i);
         end
      end
      shifted = in_data.sum << lz;
      exp_new = in_data.exp - {3'b000, lz};
      if (in_data.bypass)
         word_in = in_data.bypass_word;
      else if (in_data.sum == '0)
         word_in = '0;
      else if (in_data.sum[SUM_W-1])
         // exponent 255 carries on into the sign bit
         word_in = {in_data.sign, 31'b0} + {{1'b0, in_data.exp} + 9'd1, 23'b0}
                   + {9'b0, in_data.sum[23:1]};
      else if (in_data.exp < {3'b000, lz})
         word_in = '0;
      else
         word_in = {in_data.sign, exp_new, shifted[22:0]};
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= in_valid;
      word_ff <= word_in;
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule

// ===== rtl/core/float_add_sub.sv =====
// ----------------------------------------------------------------------------
// float_add_sub
// single-precision add/subtract, truncating, three register stages
// ----------------------------------------------------------------------------
// path: accepted start through align, add and normalize registers to rsp_valid
// throughput: one item per cycle; busy is held low, the pipeline never stalls
// stages: align shifter, significand adder, leading-one normalizer
// reset: synchronous, clears the stage valid bits; no results after reset
module float_add_sub
   import fas_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [WORD_W-1:0] req_operand_a,
   input  logic [WORD_W-1:0] req_operand_b,
   input  logic              req_opcode,
   output logic              rsp_valid,
   output logic [WORD_W-1:0] rsp_sum_bits
);

   logic      v1, v2;
   align_type d1;
   sum_type   d2;

   assign busy = 1'b0;

   fas_align u_align (
      .clock(clock), .reset(reset), .in_valid(start),
      .operand_a(req_operand_a), .operand_b(req_operand_b), .opcode(req_opcode),
      .out_valid(v1), .out_data(d1)
   );

   fas_addsub u_addsub (
      .clock(clock), .reset(reset), .in_valid(v1), .in_data(d1),
      .out_valid(v2), .out_data(d2)
   );

   fas_norm u_norm (
      .clock(clock), .reset(reset), .in_valid(v2), .in_data(d2),
      .out_valid(rsp_valid), .out_word(rsp_sum_bits)
   );

endmodule

// ===== bench/float_add_sub_tb.sv =====
// ----------------------------------------------------------------------------
// float_add_sub_tb
// self-checking bench for the single-precision add/subtract pipeline
// ----------------------------------------------------------------------------
// drives directed corner items and about a thousand random items (mostly
// normal operands with nearby exponents) with random start gaps, predicts
// each sum in a behavioral model and compares every strobed result in order
module float_add_sub_tb;
   import fas_pkg::*;

   // expected sums in order of acceptance
   class sum_scoreboard;
      logic [WORD_W-1:0] pending_sums[$];
      int errors;
      int checked;

      function void note_item(logic [WORD_W-1:0] a, logic [WORD_W-1:0] b, logic op);
         pending_sums.push_back(predict_sum(a, b, op));
      endfunction

      function void check_sum(logic [WORD_W-1:0] got);
         logic [WORD_W-1:0] want;
         if (pending_sums.size() == 0) begin
            $display("%0t: unexpected result %h", $realtime, got);
            errors++;
         end else begin
            want = pending_sums.pop_front();
            checked++;
            if (want !== got) begin
               $display("%0t: sum_bits expected %h actual %h", $realtime, want, got);
               errors++;
            end
         end
      endfunction

      // behavioral add/subtract, truncating, no special values
      function logic [WORD_W-1:0] predict_sum(logic [WORD_W-1:0] a,
            logic [WORD_W-1:0] b, logic op);
         logic sa, sb, sign;
         logic [EXP_W-1:0] ea, eb, ex;
         logic [SIG_W-1:0] big, lit;
         logic [SUM_W-1:0] sum;
         logic [WORD_W-1:0] frac;
         int diff, lead;
         sa = a[31];
         sb = b[31] ^ (op == OP_SUB);
         ea = a[30:23];
         eb = b[30:23];
         if (ea == 0) return {sb, b[30:0]};
         if (eb == 0) return a;
         if (ea > eb || (ea == eb && a[22:0] > b[22:0])) begin
            sign = sa; ex = ea; big = {1'b1, a[22:0]}; lit = {1'b1, b[22:0]};
            diff = ea - eb;
         end else begin
            sign = sb; ex = eb; big = {1'b1, b[22:0]}; lit = {1'b1, a[22:0]};
            diff = eb - ea;
         end
         lit = (diff > 23) ? '0 : lit >> diff;
         sum = (sa == sb) ? big + lit : big - lit;
         if (sum == 0) return '0;
         if (sum[24])
            return ({31'b0, sign} << 31) + ({24'b0, ex} + 32'd1 << 23)
               + {9'b0, sum[23:1]};
         lead = 1;
         while (lead <= 24 && sum[24-lead] == 1'b0) lead++;
         if (ex < lead - 1) return '0;
         frac = ({7'b0, sum} << (lead - 1)) & 32'h7fffff;
         return ({31'b0, sign} << 31) + (({24'b0, ex} - (lead - 1)) << 23) + frac;
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [WORD_W-1:0] req_operand_a = '0;
   logic [WORD_W-1:0] req_operand_b = '0;
   logic req_opcode = OP_ADD;
   logic rsp_valid;
   logic [WORD_W-1:0] rsp_sum_bits;

   sum_scoreboard board = new();
   int idle_cycles = 0;
   int items_sent = 0;
   bit timed_out = 0;

   always #1 clock = ~clock;

   float_add_sub i_dut (
      .clock, .reset, .start, .busy,
      .req_operand_a, .req_operand_b, .req_opcode,
      .rsp_valid, .rsp_sum_bits
   );

   // acceptance, result check and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) begin
            board.note_item(req_operand_a, req_operand_b, req_opcode);
            items_sent++;
         end
         if (rsp_valid) board.check_sum(rsp_sum_bits);
         if ((start && !busy) || rsp_valid) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles > 2000) begin
            $display("watchdog: no progress");
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   // present one item after a random gap and hold it until accepted
   task automatic send_item(logic [WORD_W-1:0] a, logic [WORD_W-1:0] b, logic op);
      int gap;
      gap = $urandom_range(0, 7);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start <= 1'b1;
      req_operand_a <= a;
      req_operand_b <= b;
      req_opcode <= op;
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
   endtask

   // operand with exponent near a center, clamped to 1 to 255
   function automatic logic [WORD_W-1:0] near_float(int center);
      int e;
      e = center + $urandom_range(0, 6) - 3;
      if (e < 1) e = 1;
      if (e > 255) e = 255;
      return {1'($urandom), 8'(e), 23'($urandom)};
   endfunction

   initial begin
      logic [WORD_W-1:0] a, b;
      int center, pick;
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      // directed corners
      send_item(32'h0000_0000, 32'h0000_0000, OP_SUB);
      send_item(32'h0000_1234, 32'hbf80_0000, OP_SUB);
      send_item(32'h3f80_0000, 32'h807f_ffff, OP_ADD);
      send_item(32'h3f80_0000, 32'h3f80_0000, OP_SUB);
      send_item(32'h3f80_0000, 32'hbf80_0000, OP_ADD);
      send_item(32'h3f80_0000, 32'h3f80_0000, OP_ADD);
      send_item(32'h7f7f_ffff, 32'h7f7f_ffff, OP_ADD);
      send_item(32'h7fff_ffff, 32'h7fff_ffff, OP_ADD);
      send_item(32'hffff_ffff, 32'h7fff_ffff, OP_SUB);
      send_item(32'h3f80_0000, 32'h3380_0000, OP_ADD);
      send_item(32'h3f80_0000, 32'h3300_0000, OP_SUB);
      send_item(32'h3f80_0000, 32'h0080_0000, OP_ADD);
      send_item(32'h0180_0001, 32'h0180_0000, OP_SUB);
      send_item(32'h0100_0001, 32'h0100_0000, OP_SUB);
      send_item(32'h0080_0001, 32'h0080_0000, OP_SUB);
      send_item(32'h3f80_0001, 32'h3fff_ffff, OP_SUB);
      send_item(32'hbfff_ffff, 32'h3f80_0000, OP_ADD);
      send_item(32'h4000_0000, 32'h3fff_ffff, OP_SUB);
      // let everything drain once before random traffic
      start <= 1'b0;
      while (board.pending_sums.size() != 0) @(negedge clock);
      // random traffic
      repeat (1000) begin
         pick = $urandom_range(0, 9);
         center = $urandom_range(1, 255);
         if (pick < 7) begin
            a = near_float(center);
            b = near_float(center);
            if (pick == 0) b = {~a[31], a[30:23], a[22:0] ^ 23'($urandom_range(0, 15))};
         end else if (pick == 7) begin
            a = near_float(center);
            b = near_float($urandom_range(1, 255));
         end else if (pick == 8) begin
            a = {1'($urandom), 8'd0, 23'($urandom)};
            b = $urandom;
            if ($urandom_range(0, 1)) {a, b} = {b, a};
         end else begin
            a = $urandom;
            b = $urandom;
         end
         send_item(a, b, 1'($urandom));
      end
      start <= 1'b0;
      while (board.pending_sums.size() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      $display("%0d items sent, %0d sums checked: corners, cancellation, underflow,",
         items_sent, board.checked);
      $display("exponent carry, zero-exponent bypass and random operands");
      if (board.errors == 0 && board.pending_sums.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule
